FILE: rtl/qgram_shift_or_string_matcher_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the q-gram string matcher
// Concurrent assertion helpers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef QGRAM_SHIFT_OR_STRING_MATCHER_TOP_MACROS_SVH
`define QGRAM_SHIFT_OR_STRING_MATCHER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Condition that must hold at every clock edge outside reset.
`define QSM_AST_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// Trigger in one cycle requires the consequence in the next.
`define QSM_AST_NEXT(lbl, clk, rst_n, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("assertion failed");
`else
`define QSM_AST_ALWAYS(lbl, clk, rst_n, cond)
`define QSM_AST_NEXT(lbl, clk, rst_n, trig, cons)
`endif

`endif

FILE: rtl/qsm_pkg.sv
// ----------------------------------------------------------------------------
// Package for the q-gram string matcher
// Shared constants, action codes and the verify command, write strobe and status structs.
// ----------------------------------------------------------------------------
package qsm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int ADDR_W      = 6;
    localparam int LEN_W       = 7;
    localparam int FILL_W      = 7;
    localparam int FILTER_LEN  = 28;
    localparam int GRAM_SIZE   = 4;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_TEXT  = 2'd2;

    localparam logic [2:0] REG_PATTERN_LENGTH = 3'd0;

    // Start of one verification run.
    typedef struct packed {
        logic              go;
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  len;
    } t_ver_cmd;

    // Write strobes for the two byte memories.
    typedef struct packed {
        logic              pat_we;
        logic [ADDR_W-1:0] pat_addr;
        logic              win_we;
        logic [ADDR_W-1:0] win_addr;
        logic [7:0]        wdata;
    } t_mem_wr;

    typedef struct packed {
        logic busy;
        logic done;
        logic hit;
    } t_ver_sts;

endpackage

FILE: rtl/qsm_if.sv
// ----------------------------------------------------------------------------
// Channel interfaces for the q-gram string matcher
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface qsm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [5:0] pattern_index;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, action, pattern_index, data_byte, last_byte,
                    input ready);
    modport sink   (input valid, action, pattern_index, data_byte, last_byte,
                    output ready);
endinterface

interface qsm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] match_start;

    modport source (output valid, match_start, input ready);
    modport sink   (input valid, match_start, output ready);
endinterface

FILE: rtl/qsm_verify.sv
// ----------------------------------------------------------------------------
// Verification unit
// Holds pattern and text window memories and compares one byte pair per pass.
// ----------------------------------------------------------------------------
module qsm_verify (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  qsm_pkg::t_ver_cmd i_cmd,
    input  qsm_pkg::t_mem_wr  i_wr,
    input  logic              i_ack,
    output qsm_pkg::t_ver_sts o_sts
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_CMP  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [7:0] pat_mem [qsm_pkg::MAX_PATTERN];
    logic [7:0] win_mem [qsm_pkg::MAX_PATTERN];

    logic [qsm_pkg::ADDR_W-1:0] r_base, r_j;
    logic [qsm_pkg::LEN_W-1:0]  r_len;
    logic [7:0]                 r_pat_q, r_win_q;
    logic                       r_hit;

    // Memory writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (i_wr.pat_we) begin
            pat_mem[i_wr.pat_addr] <= i_wr.wdata;
        end
        if (i_wr.win_we) begin
            win_mem[i_wr.win_addr] <= i_wr.wdata;
        end
        r_pat_q <= pat_mem[r_j];
        r_win_q <= win_mem[r_base + r_j];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_cmd.go) n_state = S_RD;
            S_RD:   n_state = S_CMP;
            S_CMP: begin
                if (r_pat_q != r_win_q || {1'b0, r_j} == r_len - 7'd1) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_DONE: if (i_ack) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CMP) begin
                r_hit <= (r_pat_q == r_win_q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd.go) begin
            r_base <= i_cmd.base;
            r_len  <= i_cmd.len;
            r_j    <= '0;
        end else if (r_state == S_CMP) begin
            r_j <= r_j + 6'd1;
        end
    end

    assign o_sts.busy = (r_state != S_IDLE);
    assign o_sts.done = (r_state == S_DONE);
    assign o_sts.hit  = r_hit;

endmodule

FILE: rtl/qgram_shift_or_string_matcher_top.sv
// ----------------------------------------------------------------------------
// q-gram string matcher, top level
// Finds every occurrence of a loaded pattern in a stream of text bytes.
// ----------------------------------------------------------------------------
// Each input word is a clear, a pattern byte load or a text byte. A text
// byte whose window can hold an occurrence (enough bytes seen, length at
// least four, the filter prefix fully loaded) starts a verification run in
// which one shared byte comparator checks one pattern byte per pass, each
// pass reading both byte memories through a registered port and then
// comparing. The run stops at the first mismatch or after the full length.
// Input words are not taken while a run is busy. A result word is held in an
// output register; the block takes new input words while it waits, and a run
// holds in its done state if a second hit is ready before the first one is
// taken. The pattern length register is written over APB at address 0
// and should only be changed while the block is idle.
`include "qgram_shift_or_string_matcher_top_macros.svh"

module qgram_shift_or_string_matcher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qsm_in_if.sink      i_in_ch,
    qsm_out_if.source   o_out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [qsm_pkg::LEN_W-1:0]       r_plen;
    logic [qsm_pkg::MAX_PATTERN-1:0] r_loaded;
    logic [qsm_pkg::ADDR_W-1:0]      r_wptr;
    logic [qsm_pkg::FILL_W-1:0]      r_fill;
    logic [31:0]                     r_pos;
    logic [31:0]                     r_start;
    logic                            r_out_valid;
    logic [31:0]                     r_out_data;

    logic [qsm_pkg::LEN_W-1:0]       w_len, w_flen;
    logic [qsm_pkg::FILL_W-1:0]      w_fill_inc;
    logic [qsm_pkg::MAX_PATTERN-1:0] w_mask;
    logic                            w_loaded_ok;
    logic                            w_accept, w_text, w_ack;
    qsm_pkg::t_ver_cmd               w_cmd;
    qsm_pkg::t_mem_wr                w_wr;
    qsm_pkg::t_ver_sts               w_sts;

    // APB register port.
    assign pready = 1'b1;
    assign prdata = (paddr == qsm_pkg::REG_PATTERN_LENGTH) ? {25'd0, r_plen} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= 7'd4;
        end else if (psel && penable && pwrite && paddr == qsm_pkg::REG_PATTERN_LENGTH) begin
            r_plen <= pwdata[6:0];
        end
    end

    // Effective length and filter prefix length.
    assign w_len  = (r_plen > 7'(qsm_pkg::MAX_PATTERN)) ? 7'(qsm_pkg::MAX_PATTERN) : r_plen;
    assign w_flen = (w_len > 7'(qsm_pkg::FILTER_LEN)) ? 7'(qsm_pkg::FILTER_LEN) : w_len;

    always_comb begin
        for (int k = 0; k < qsm_pkg::MAX_PATTERN; k++) begin
            w_mask[k] = (7'(k) < w_flen);
        end
    end
    assign w_loaded_ok = &(r_loaded | ~w_mask);

    assign w_fill_inc = (r_fill < 7'(qsm_pkg::MAX_PATTERN)) ? r_fill + 7'd1 : r_fill;

    assign i_in_ch.ready = !w_sts.busy;
    assign w_accept = i_in_ch.valid && i_in_ch.ready;
    assign w_text   = w_accept && i_in_ch.action == qsm_pkg::ACT_TEXT;

    // A verification run starts only where an occurrence can end here.
    assign w_cmd.go   = w_text && w_len >= 7'(qsm_pkg::GRAM_SIZE) &&
                        w_fill_inc >= w_len && w_loaded_ok;
    assign w_cmd.base = r_wptr - w_len[5:0] + 6'd1;
    assign w_cmd.len  = w_len;

    assign w_wr.pat_we   = w_accept && i_in_ch.action == qsm_pkg::ACT_LOAD;
    assign w_wr.pat_addr = i_in_ch.pattern_index;
    assign w_wr.win_we   = w_text;
    assign w_wr.win_addr = r_wptr;
    assign w_wr.wdata    = i_in_ch.data_byte;

    // The run may finish only when its hit can go into the output register.
    assign w_ack = !w_sts.hit || !r_out_valid || o_out_ch.ready;

    qsm_verify u_verify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_wr    (w_wr),
        .i_ack   (w_ack),
        .o_sts   (w_sts)
    );

    // Text bookkeeping: window pointer, fill count, position and loaded bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
            r_wptr   <= '0;
            r_fill   <= '0;
            r_pos    <= '0;
        end else if (w_accept) begin
            case (i_in_ch.action)
                qsm_pkg::ACT_CLEAR: begin
                    r_loaded <= '0;
                    r_wptr   <= '0;
                    r_fill   <= '0;
                    r_pos    <= '0;
                end
                qsm_pkg::ACT_LOAD: begin
                    r_loaded[i_in_ch.pattern_index] <= 1'b1;
                end
                qsm_pkg::ACT_TEXT: begin
                    if (i_in_ch.last_byte) begin
                        r_wptr <= '0;
                        r_fill <= '0;
                        r_pos  <= '0;
                    end else begin
                        r_wptr <= r_wptr + 6'd1;
                        r_fill <= w_fill_inc;
                        r_pos  <= r_pos + 32'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.go) begin
            r_start <= r_pos - 32'(w_len - 7'd1);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_sts.done && w_sts.hit && w_ack) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sts.done && w_sts.hit && w_ack) begin
            r_out_data <= r_start;
        end
    end

    assign o_out_ch.valid       = r_out_valid;
    assign o_out_ch.match_start = r_out_data;

    `QSM_AST_ALWAYS(a_no_accept_busy, i_clk, i_rst_n, !(w_accept && w_sts.busy))
    `QSM_AST_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill <= 7'(qsm_pkg::MAX_PATTERN))
    `QSM_AST_NEXT(a_clear_pos, i_clk, i_rst_n, w_accept && i_in_ch.action == qsm_pkg::ACT_CLEAR, r_pos == 32'd0 && r_loaded == '0)
    `QSM_AST_NEXT(a_go_busy, i_clk, i_rst_n, w_cmd.go, w_sts.busy)

endmodule
